FILE: rtl/core/prz_pkg.sv
package prz_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 44;
  localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int HALF_W        = SCREEN_WIDTH / 2;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;
  localparam int ADDR_W        = $clog2(PIX_COUNT);
  localparam int PIX_W         = $clog2(PIX_COUNT + 1);

  // Field widths
  localparam int IDX_W    = 13;
  localparam int CMP_W    = (PIX_W > IDX_W) ? PIX_W : IDX_W;
  localparam int COORD_W  = 16;
  localparam int GLYPH_W  = 8;
  localparam int DEPTH_W  = 16;
  localparam int MEM_W    = DEPTH_W + GLYPH_W;

  localparam logic [GLYPH_W-1:0] BLANK     = 8'd32;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFF;
  localparam logic               FUNC_PLOT = 1'b0;
  localparam logic               FUNC_READ = 1'b1;

  // Datapath widths
  localparam int COEF_W    = 20;
  localparam int MUL_W     = 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 40;
  localparam int ROT_W     = 24;
  localparam int NUM_W     = 34;
  localparam int IDXF_W    = NUM_W + 12;
  localparam int Q_HALF    = 8192;
  localparam int Q_SHIFT   = 14;
  localparam int DEPTH_NUM = 1 << 24;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Item queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int NUM_REGS = 8;
  localparam int PADDR_W  = $clog2(NUM_REGS * 4);
  localparam int PDATA_W  = 32;

  localparam logic signed [COORD_W-1:0] TRIG_ONE  = 16'sd16384;
  localparam logic signed [COORD_W-1:0] TRIG_ZERO = 16'sd0;
  localparam logic [7:0] CAM_RESET   = 8'd60;
  localparam logic [7:0] SCALE_RESET = 8'd40;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [ROT_W-1:0]   rot_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic signed [NUM_W:0]     quo_t;
  typedef logic signed [IDXF_W-1:0]  idx_t;

  typedef enum logic [2:0] {
    REG_SIN_A, REG_COS_A, REG_SIN_B, REG_COS_B,
    REG_SIN_C, REG_COS_C, REG_CAM, REG_SCALE
  } reg_idx_t;

  typedef struct packed {
    coord_t     sin_a;
    coord_t     cos_a;
    coord_t     sin_b;
    coord_t     cos_b;
    coord_t     sin_c;
    coord_t     cos_c;
    logic [7:0] camera_distance;
    logic [7:0] projection_scale;
  } cfg_t;

  typedef struct packed {
    logic               func;
    coord_t             point_x;
    coord_t             point_y;
    coord_t             point_z;
    logic [GLYPH_W-1:0] glyph;
    logic [IDX_W-1:0]   read_index;
  } item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [GLYPH_W-1:0] glyph;
  } mem_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_DLOAD, ST_DIV,
    ST_INDEX, ST_RANGE, ST_RD, ST_RDW, ST_OUT
  } state_t;

  typedef enum logic [1:0] {DV_X, DV_Y, DV_D} div_sel_t;

  typedef enum logic [4:0] {
    S_SASB, S_CASB, S_XI, S_XJ0, S_XJ1, S_XK0, S_XK1,
    S_YI, S_YJ0, S_YJ1, S_YK0, S_YK1, S_ZJ, S_ZK,
    S_RX0, S_RX1, S_RX2, S_RY0, S_RY1, S_RY2, S_RZ0, S_RZ1, S_RZ2,
    S_NX0, S_NX1, S_NY0, S_NY1
  } step_t;

endpackage

FILE: rtl/core/prz_chan_if.sv
interface prz_in_if;
  import prz_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  coord_t             point_x;
  coord_t             point_y;
  coord_t             point_z;
  logic [GLYPH_W-1:0] glyph;
  logic [IDX_W-1:0]   read_index;

  modport source (output valid, func, point_x, point_y, point_z, glyph, read_index,
                  input ready);
  modport sink (input valid, func, point_x, point_y, point_z, glyph, read_index,
                output ready);
endinterface

interface prz_out_if;
  import prz_pkg::*;
  logic               valid;
  logic               ready;
  logic               written;
  logic [IDX_W-1:0]   pixel_index;
  logic [GLYPH_W-1:0] pixel_glyph;

  modport source (output valid, written, pixel_index, pixel_glyph, input ready);
  modport sink (input valid, written, pixel_index, pixel_glyph, output ready);
endinterface

FILE: rtl/core/prz_ram.sv
module prz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/prz_front.sv
module prz_front (
  input  logic                          clk,
  input  logic                          rst,
  prz_in_if.sink                        req,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prz_pkg::PADDR_W-1:0]   paddr,
  input  logic [prz_pkg::PDATA_W-1:0]   pwdata,
  output logic [prz_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output prz_pkg::cfg_t                 cfg,
  output logic                          q_valid,
  output prz_pkg::item_t                q_item,
  input  logic                          q_pop,
  input  logic                          clearing
);
  import prz_pkg::*;

  item_t             qmem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  // Accept a beat when the queue has room and the store is not being cleared
  assign req.ready = (count != QCNT_W'(QDEPTH)) && !clearing;
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign q_item    = qmem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= '{func: req.func, point_x: req.point_x, point_y: req.point_y,
                        point_z: req.point_z, glyph: req.glyph,
                        read_index: req.read_index};
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sin_a            <= TRIG_ZERO;
      cfg.cos_a            <= TRIG_ONE;
      cfg.sin_b            <= TRIG_ZERO;
      cfg.cos_b            <= TRIG_ONE;
      cfg.sin_c            <= TRIG_ZERO;
      cfg.cos_c            <= TRIG_ONE;
      cfg.camera_distance  <= CAM_RESET;
      cfg.projection_scale <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SIN_A: cfg.sin_a            <= coord_t'(pwdata[COORD_W-1:0]);
        REG_COS_A: cfg.cos_a            <= coord_t'(pwdata[COORD_W-1:0]);
        REG_SIN_B: cfg.sin_b            <= coord_t'(pwdata[COORD_W-1:0]);
        REG_COS_B: cfg.cos_b            <= coord_t'(pwdata[COORD_W-1:0]);
        REG_SIN_C: cfg.sin_c            <= coord_t'(pwdata[COORD_W-1:0]);
        REG_COS_C: cfg.cos_c            <= coord_t'(pwdata[COORD_W-1:0]);
        REG_CAM:   cfg.camera_distance  <= pwdata[7:0];
        REG_SCALE: cfg.projection_scale <= pwdata[7:0];
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_SIN_A: prdata = PDATA_W'(cfg.sin_a);
      REG_COS_A: prdata = PDATA_W'(cfg.cos_a);
      REG_SIN_B: prdata = PDATA_W'(cfg.sin_b);
      REG_COS_B: prdata = PDATA_W'(cfg.cos_b);
      REG_SIN_C: prdata = PDATA_W'(cfg.sin_c);
      REG_COS_C: prdata = PDATA_W'(cfg.cos_c);
      REG_CAM:   prdata = PDATA_W'(cfg.camera_distance);
      REG_SCALE: prdata = PDATA_W'(cfg.projection_scale);
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("item queue overfilled");
  a_hold_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("beat taken during store clear");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif
endmodule

FILE: rtl/core/prz_back.sv
module prz_back (
  input  logic           clk,
  input  logic           rst,
  input  prz_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  prz_pkg::item_t q_item,
  output logic           q_pop,
  output logic           clearing,
  prz_out_if.source      rsp
);
  import prz_pkg::*;

  state_t                state;
  state_t                state_next;
  step_t                 step;
  logic                  phase;
  div_sel_t              div_sel;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     mem_addr;
  item_t                 item;
  coef_t                 sasb, casb, xi, xj, xk, yi, yj, yk, zj, zk;
  mul_t                  opa, opb;
  prod_t                 prod;
  prod_t                 qr;
  acc_t                  acc;
  acc_t                  acc_sum;
  rot_t                  rx, ry, zq;
  rot_t                  rsum_q;
  num_t                  numx, numy;
  num_t                  div_num;
  logic [NUM_W-1:0]      div_quo;
  logic [NUM_W-1:0]      quo_next;
  logic [ROT_W:0]        div_rem;
  logic [ROT_W:0]        rem_sh;
  logic [ROT_W:0]        rem_next;
  logic [ROT_W:0]        dvs;
  logic                  div_neg;
  logic                  div_bit;
  quo_t                  div_res;
  quo_t                  xp, yp;
  idx_t                  idx_full;
  logic                  idx_ok;
  logic                  rd_ok;
  logic [DEPTH_W-1:0]    depth;
  logic                  better;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  mem_word_t             ram_wdata;
  mem_word_t             ram_rdata;
  logic                  res_written;
  logic [IDX_W-1:0]      res_pix;
  logic [GLYPH_W-1:0]    res_glyph;

  // Pixel store: depth and glyph in one word
  prz_ram #(.WIDTH(MEM_W), .DEPTH(PIX_COUNT)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (mem_addr),
    .rdata (ram_rdata)
  );

  // Multiplier operand select per step
  always_comb begin
    unique case (step)
      S_SASB:  begin opa = mul_t'(cfg.sin_a); opb = mul_t'(cfg.sin_b); end
      S_CASB:  begin opa = mul_t'(cfg.cos_a); opb = mul_t'(cfg.sin_b); end
      S_XI:    begin opa = mul_t'(cfg.cos_b); opb = mul_t'(cfg.cos_c); end
      S_XJ0:   begin opa = mul_t'(sasb);      opb = mul_t'(cfg.cos_c); end
      S_XJ1:   begin opa = mul_t'(cfg.cos_a); opb = mul_t'(cfg.sin_c); end
      S_XK0:   begin opa = mul_t'(cfg.sin_a); opb = mul_t'(cfg.sin_c); end
      S_XK1:   begin opa = mul_t'(casb);      opb = mul_t'(cfg.cos_c); end
      S_YI:    begin opa = mul_t'(cfg.cos_b); opb = mul_t'(cfg.sin_c); end
      S_YJ0:   begin opa = mul_t'(cfg.cos_a); opb = mul_t'(cfg.cos_c); end
      S_YJ1:   begin opa = mul_t'(sasb);      opb = mul_t'(cfg.sin_c); end
      S_YK0:   begin opa = mul_t'(cfg.sin_a); opb = mul_t'(cfg.cos_c); end
      S_YK1:   begin opa = mul_t'(casb);      opb = mul_t'(cfg.sin_c); end
      S_ZJ:    begin opa = mul_t'(cfg.sin_a); opb = mul_t'(cfg.cos_b); end
      S_ZK:    begin opa = mul_t'(cfg.cos_a); opb = mul_t'(cfg.cos_b); end
      S_RX0:   begin opa = mul_t'(item.point_x); opb = mul_t'(xi); end
      S_RX1:   begin opa = mul_t'(item.point_y); opb = mul_t'(xj); end
      S_RX2:   begin opa = mul_t'(item.point_z); opb = mul_t'(xk); end
      S_RY0:   begin opa = mul_t'(item.point_x); opb = mul_t'(yi); end
      S_RY1:   begin opa = mul_t'(item.point_y); opb = mul_t'(yj); end
      S_RY2:   begin opa = mul_t'(item.point_z); opb = mul_t'(yk); end
      S_RZ0:   begin opa = mul_t'(item.point_x); opb = mul_t'(cfg.sin_b); end
      S_RZ1:   begin opa = mul_t'(item.point_y); opb = mul_t'(zj); end
      S_RZ2:   begin opa = mul_t'(item.point_z); opb = mul_t'(zk); end
      S_NX0:   begin opa = mul_t'(zq); opb = mul_t'(HALF_W); end
      S_NX1:   begin
        opa = mul_t'(rx);
        opb = mul_t'($signed({1'b0, cfg.projection_scale, 1'b0}));
      end
      S_NY0:   begin opa = mul_t'(zq); opb = mul_t'(HALF_H); end
      S_NY1:   begin
        opa = mul_t'(ry);
        opb = mul_t'($signed({1'b0, cfg.projection_scale}));
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Rounding of products and sums back to fixed point
  assign qr      = (prod + prod_t'(Q_HALF)) >>> Q_SHIFT;
  assign acc_sum = acc + acc_t'(prod);
  assign rsum_q  = rot_t'((acc_sum + acc_t'(Q_HALF)) >>> Q_SHIFT);

  // Divider step: restoring, one quotient bit a cycle
  assign dvs      = {1'b0, zq};
  assign rem_sh   = {div_rem[ROT_W-1:0], div_quo[NUM_W-1]};
  assign div_bit  = (rem_sh >= dvs);
  assign rem_next = div_bit ? (rem_sh - dvs) : rem_sh;
  assign quo_next = {div_quo[NUM_W-2:0], div_bit};
  assign div_res  = div_neg ? -quo_t'({1'b0, quo_next}) : quo_t'({1'b0, quo_next});

  always_comb begin
    unique case (div_sel)
      DV_X:    div_num = numx;
      DV_Y:    div_num = numy;
      DV_D:    div_num = num_t'(DEPTH_NUM);
      default: div_num = '0;
    endcase
  end

  assign idx_ok = !idx_full[IDXF_W-1] && (idx_full < idx_t'(PIX_COUNT));
  assign rd_ok  = CMP_W'(q_item.read_index) < CMP_W'(PIX_COUNT);
  assign better = depth > ram_rdata.depth;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(PIX_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.func == FUNC_READ) state_next = rd_ok ? ST_RD : ST_OUT;
          else                          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (phase && step == S_NY1) state_next = (zq > 0) ? ST_DLOAD : ST_OUT;
      end
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          unique case (div_sel)
            DV_X:    state_next = ST_DLOAD;
            DV_Y:    state_next = ST_INDEX;
            DV_D:    state_next = ST_RD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_INDEX: state_next = ST_RANGE;
      ST_RANGE: state_next = idx_ok ? ST_DLOAD : ST_OUT;
      ST_RD:    state_next = ST_RDW;
      ST_RDW:   state_next = ST_OUT;
      ST_OUT: begin
        if (rsp.ready) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Outputs: queue pop, store write port, result beat
  always_comb begin
    q_pop           = (state == ST_IDLE) && q_valid;
    clearing        = (state == ST_CLEAR);
    rsp.valid       = (state == ST_OUT);
    rsp.written     = res_written;
    rsp.pixel_index = res_pix;
    rsp.pixel_glyph = res_glyph;
    ram_we          = 1'b0;
    ram_waddr       = mem_addr;
    ram_wdata       = '{depth: '0, glyph: BLANK};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_RDW: begin
        if (item.func == FUNC_READ) begin
          ram_we = 1'b1;
        end else begin
          ram_we    = better;
          ram_wdata = '{depth: depth, glyph: item.glyph};
        end
      end
      default: ;
    endcase
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      step     <= S_SASB;
      phase    <= 1'b0;
      div_sel  <= DV_X;
      div_cnt  <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          step    <= S_SASB;
          phase   <= 1'b0;
          div_sel <= DV_X;
        end
        ST_MUL: begin
          phase <= !phase;
          if (phase && step != S_NY1) step <= step_t'(step + 1'b1);
        end
        ST_DLOAD: div_cnt <= '0;
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1) && div_sel == DV_X) div_sel <= DV_Y;
        end
        ST_RANGE: div_sel <= DV_D;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        item     <= q_item;
        mem_addr <= ADDR_W'(q_item.read_index);
        res_written <= 1'b0;
        res_pix     <= q_item.read_index;
        res_glyph   <= BLANK;
      end
      ST_MUL: begin
        if (!phase) begin
          prod <= opa * opb;
        end else begin
          unique case (step)
            S_SASB:  sasb <= coef_t'(qr);
            S_CASB:  casb <= coef_t'(qr);
            S_XI:    xi   <= coef_t'(qr);
            S_XJ0:   xj   <= coef_t'(qr);
            S_XJ1:   xj   <= xj + coef_t'(qr);
            S_XK0:   xk   <= coef_t'(qr);
            S_XK1:   xk   <= xk - coef_t'(qr);
            S_YI:    yi   <= -coef_t'(qr);
            S_YJ0:   yj   <= coef_t'(qr);
            S_YJ1:   yj   <= yj - coef_t'(qr);
            S_YK0:   yk   <= coef_t'(qr);
            S_YK1:   yk   <= yk + coef_t'(qr);
            S_ZJ:    zj   <= -coef_t'(qr);
            S_ZK:    zk   <= coef_t'(qr);
            S_RX0, S_RY0, S_RZ0: acc <= acc_t'(prod);
            S_RX1, S_RY1, S_RZ1: acc <= acc_sum;
            S_RX2:   rx <= rsum_q;
            S_RY2:   ry <= rsum_q;
            S_RZ2:   zq <= rsum_q + rot_t'($signed({1'b0, cfg.camera_distance, 8'h00}));
            S_NX0:   numx <= num_t'(prod);
            S_NX1:   numx <= numx + num_t'(prod);
            S_NY0:   numy <= num_t'(prod);
            S_NY1: begin
              numy        <= numy + num_t'(prod);
              res_written <= 1'b0;
              res_pix     <= '0;
              res_glyph   <= '0;
            end
            default: ;
          endcase
        end
      end
      ST_DLOAD: begin
        div_neg <= div_num[NUM_W-1];
        div_quo <= div_num[NUM_W-1] ? NUM_W'(-div_num) : NUM_W'(div_num);
        div_rem <= '0;
      end
      ST_DIV: begin
        div_rem <= rem_next;
        div_quo <= quo_next;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          unique case (div_sel)
            DV_X: xp <= div_res;
            DV_Y: yp <= div_res;
            DV_D: depth <= (quo_next > NUM_W'(DEPTH_MAX)) ? DEPTH_MAX
                                                          : quo_next[DEPTH_W-1:0];
            default: ;
          endcase
        end
      end
      ST_INDEX: idx_full <= idx_t'(xp) + idx_t'(yp) * idx_t'(SCREEN_WIDTH);
      ST_RANGE: mem_addr <= ADDR_W'(idx_full);
      ST_RDW: begin
        if (item.func == FUNC_READ) begin
          res_written <= 1'b0;
          res_pix     <= item.read_index;
          res_glyph   <= ram_rdata.glyph;
        end else begin
          res_written <= better;
          res_pix     <= IDX_W'(idx_full);
          res_glyph   <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_written_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.written |-> (CMP_W'(rsp.pixel_index) < CMP_W'(PIX_COUNT)))
    else $error("stored pixel index out of range");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready |=> !rsp.valid)
    else $error("result beat repeated");
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    ram_we && state != ST_CLEAR |-> $past(state) == ST_RD)
    else $error("store write without preceding read");
`endif
endmodule

FILE: rtl/core/point_rotate_project_zbuffer.sv
// Point rotate, perspective project and depth-buffered character plot.
// Channel req (valid/ready) carries plot items (func 0: point in Q8.8 and a
// glyph) and read items (func 1: pixel index). Channel rsp returns one beat
// per item: written flag, pixel index and, for a read, the glyph held before
// the pixel was cleared to blank. Rotation sines/cosines, camera distance and
// projection scale sit in APB registers, which the user must write only while
// the block is idle (not enforced). A two-entry queue takes beats while the
// back end works or while a result waits on a stalled receiver; rsp holds its
// beat until taken. A plot uses the shared 25x25 multiplier (27 steps) and
// the radix-2 divider (three divisions). Items run one at a time.
// Reset returns the registers to their defaults and starts a clearing pass
// over the 7040-entry pixel store, one entry a cycle; req.ready stays low
// until the pass ends. Register writes are taken throughout.
module point_rotate_project_zbuffer (
  input  logic                        clk,
  input  logic                        rst,
  prz_in_if.sink                      req,
  prz_out_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prz_pkg::PADDR_W-1:0] paddr,
  input  logic [prz_pkg::PDATA_W-1:0] pwdata,
  output logic [prz_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import prz_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  clearing;

  // Front: item queue and registers
  prz_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing)
  );

  // Back: arithmetic sequencer and pixel store
  prz_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp      (rsp)
  );
endmodule

FILE: test/prz_tb_if.sv
`timescale 1ns / 100ps
// Channel bundles are the RTL interfaces prz_in_if / prz_out_if; this file
// holds the beat record (plot or read item) used by the stimulus.
package prz_tb_pkg;
  import prz_pkg::*;

  typedef struct {
    logic       func;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic [7:0] glyph;
    logic [12:0] ridx;
  } beat_t;
endpackage

FILE: test/prz_checker.sv
`timescale 1ns / 100ps
module prz_checker
  import prz_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  prz_in_if               req,
  prz_out_if              rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int              fails,
  output int              pending
);

  typedef struct {
    logic        written;
    logic [12:0] index;
    logic [7:0]  glyph;
  } pixel_result_t;

  longint shadow_cfg[NUM_REGS];
  logic [15:0] depth_mem[PIX_COUNT];
  logic [7:0]  glyph_mem[PIX_COUNT];
  pixel_result_t expected_pixels[$];

  function automatic longint q14(longint p, longint q);
    return (p * q + 8192) >>> 14;
  endfunction

  // Rotate, project and depth-test one plot beat, or read-and-clear a pixel.
  function automatic pixel_result_t project_point(logic func, coord_t px, coord_t py,
                                                  coord_t pz, logic [7:0] g,
                                                  logic [12:0] ri);
    pixel_result_t r;
    longint sa, ca, sb, cb, sc, cc, sasb, casb;
    longint xi, xj, xk, yi, yj, yk, zi, zj, zk, rx, ry, rz, zq, xp, yp, idx, d;
    r = '{1'b0, 13'd0, 8'd0};
    if (func == FUNC_READ) begin
      r.index = ri;
      r.glyph = BLANK;
      if (ri < PIX_COUNT) begin
        r.glyph = glyph_mem[ri];
        glyph_mem[ri] = BLANK;
        depth_mem[ri] = '0;
      end
      return r;
    end
    sa = shadow_cfg[REG_SIN_A]; ca = shadow_cfg[REG_COS_A];
    sb = shadow_cfg[REG_SIN_B]; cb = shadow_cfg[REG_COS_B];
    sc = shadow_cfg[REG_SIN_C]; cc = shadow_cfg[REG_COS_C];
    sasb = q14(sa, sb); casb = q14(ca, sb);
    xi = q14(cb, cc);
    xj = q14(sasb, cc) + q14(ca, sc);
    xk = q14(sa, sc) - q14(casb, cc);
    yi = -q14(cb, sc);
    yj = q14(ca, cc) - q14(sasb, sc);
    yk = q14(sa, cc) + q14(casb, sc);
    zi = sb; zj = -q14(sa, cb); zk = q14(ca, cb);
    rx = (px * xi + py * xj + pz * xk + 8192) >>> 14;
    ry = (px * yi + py * yj + pz * yk + 8192) >>> 14;
    rz = (px * zi + py * zj + pz * zk + 8192) >>> 14;
    zq = rz + shadow_cfg[REG_CAM] * 256;
    if (zq <= 0) return r;
    xp = (HALF_W * zq + 2 * shadow_cfg[REG_SCALE] * rx) / zq;
    yp = (HALF_H * zq + shadow_cfg[REG_SCALE] * ry) / zq;
    idx = xp + yp * SCREEN_WIDTH;
    if (idx < 0 || idx >= PIX_COUNT) return r;
    d = (64'sd1 << 24) / zq;
    if (d > 65535) d = 65535;
    r.index = idx[12:0];
    if (d[15:0] > depth_mem[idx]) begin
      depth_mem[idx] = d[15:0];
      glyph_mem[idx] = g;
      r.written = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      fails = 0;
      shadow_cfg = '{0, 16384, 0, 16384, 0, 16384, 60, 40};
      for (int i = 0; i < PIX_COUNT; i++) begin
        depth_mem[i] = '0;
        glyph_mem[i] = BLANK;
      end
      expected_pixels.delete();
    end else begin
      // mirror register writes
      if (psel && penable && pwrite) begin
        if (paddr[PADDR_W-1:2] < REG_CAM)
          shadow_cfg[paddr[PADDR_W-1:2]] = longint'($signed(pwdata[15:0]));
        else
          shadow_cfg[paddr[PADDR_W-1:2]] = longint'(pwdata[7:0]);
      end
      // compare result beat with oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected beat", rsp.pixel_index, -1);
        end else begin
          want = expected_pixels.pop_front();
          if (rsp.written !== want.written)
            report_mismatch("written", rsp.written, want.written);
          if (rsp.pixel_index !== want.index)
            report_mismatch("pixel_index", rsp.pixel_index, want.index);
          if (rsp.pixel_glyph !== want.glyph)
            report_mismatch("pixel_glyph", rsp.pixel_glyph, want.glyph);
        end
      end
      // predict on accepted input beat
      if (req.valid && req.ready)
        expected_pixels.push_back(project_point(req.func, req.point_x, req.point_y,
                                                req.point_z, req.glyph, req.read_index));
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
module tb;
  import prz_pkg::*;
  import prz_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  int fails, pending;
  longint cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  prz_in_if  req ();
  prz_out_if rsp ();

  point_rotate_project_zbuffer dut (
    .clk, .rst, .req(req.sink), .rsp(rsp.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  prz_checker chk (
    .clk, .rst, .req, .rsp, .psel, .penable, .pwrite, .paddr, .pwdata,
    .fails, .pending
  );

  always #10 clk = ~clk;

  initial begin
    req.valid = 1'b0; req.func = FUNC_PLOT; req.point_x = '0; req.point_y = '0;
    req.point_z = '0; req.glyph = '0; req.read_index = '0;
    rsp.ready = 1'b0;
  end

  // timeout: covers plot beats, stalls, the clearing pass and a margin
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("[point_rotate_project_zbuffer] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // offer one beat, with an optional idle burst first
  task automatic send(beat_t b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req.valid <= 1'b1; req.func <= b.func; req.point_x <= b.x; req.point_y <= b.y;
    req.point_z <= b.z; req.glyph <= b.glyph; req.read_index <= b.ridx;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic beat_t plot(int x, int y, int z, int g);
    beat_t b;
    b.func = FUNC_PLOT; b.x = x; b.y = y; b.z = z; b.glyph = g;
    b.ridx = $urandom_range(0, 8191);
    return b;
  endfunction

  function automatic beat_t readback(int i);
    beat_t b;
    b.func = FUNC_READ; b.x = $urandom; b.y = $urandom; b.z = $urandom;
    b.glyph = $urandom; b.ridx = i;
    return b;
  endfunction

  // small points near the view axis hit the screen; some are wild
  function automatic beat_t rand_beat();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 4) == 0 ? readback($urandom_range(0, 8191))
                                       : readback($urandom_range(0, PIX_COUNT - 1));
    if ($urandom_range(0, 7) == 0)
      return plot($signed(16'($urandom)), $signed(16'($urandom)),
                  $signed(16'($urandom)), $urandom_range(0, 255));
    return plot($urandom_range(0, 8000) - 4000, $urandom_range(0, 4000) - 2000,
                $urandom_range(0, 16000) - 8000, $urandom_range(0, 255));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, behind camera, depth test, reads in and out of range
    send(plot(0, 0, 0, 8'h41));
    send(plot(0, 0, 0, 8'h42));
    send(plot(0, 0, 256, 8'h43));
    send(readback(22 * SCREEN_WIDTH + 80));
    send(readback(22 * SCREEN_WIDTH + 80));
    send(plot(32767, 32767, 32767, 255));
    send(plot(-32768, -32768, -32768, 0));
    send(plot(0, 0, -32768, 7));
    send(plot(32767, -32768, 0, 9));
    send(readback(0));
    send(readback(PIX_COUNT - 1));
    send(readback(PIX_COUNT));
    send(readback(8191));
    drain();

    // extreme settings
    write_reg(REG_SIN_A, -16384); write_reg(REG_COS_A, 16384);
    write_reg(REG_SIN_B, 16384);  write_reg(REG_COS_B, -16384);
    write_reg(REG_SIN_C, 11585);  write_reg(REG_COS_C, 11585);
    write_reg(REG_CAM, 255);      write_reg(REG_SCALE, 255);
    for (int i = 0; i < 8; i++) send(rand_beat());
    send(plot(0, 0, 0, 1));
    drain();
    write_reg(REG_CAM, 0); write_reg(REG_SCALE, 0);
    for (int i = 0; i < 8; i++) send(rand_beat());
    send(plot(0, 0, 256, 2));
    drain();

    // random phases with random settings, long receiver stall in the first
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 6; r++)
        write_reg(reg_idx_t'(r), $urandom_range(0, 32768) - 16384);
      write_reg(REG_CAM, $urandom_range(10, 255));
      write_reg(REG_SCALE, $urandom_range(0, 255));
      if (ph == 0) hold_off = 1'b1;
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 250; i++) send(rand_beat());
      drain();
    end

    if (fails == 0)
      $display("[point_rotate_project_zbuffer] OK");
    else
      $display("[point_rotate_project_zbuffer] ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/prz_pkg.sv
rtl/core/prz_chan_if.sv
rtl/core/prz_ram.sv
rtl/core/prz_front.sv
rtl/core/prz_back.sv
rtl/core/point_rotate_project_zbuffer.sv
test/prz_tb_if.sv
test/prz_checker.sv
test/tb.sv
